/* design/ftr_pkg.sv */
package ftr_pkg;

    localparam int DEPTH  = 1024;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int FUNC_W = 3;
    localparam int POS_W  = 10;
    localparam int HELD_W = 11;
    localparam int WORD_W = 64;

    localparam int ADDR_W = 5;
    localparam int RIDX_W = 2;

    localparam logic [FUNC_W-1:0] FN_STEP   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ARM    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DISARM = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd4;

    localparam logic [RIDX_W-1:0] REG_SPACE_FILTER = 2'd0;
    localparam logic [RIDX_W-1:0] REG_END_ADDRESS  = 2'd1;
    localparam logic [RIDX_W-1:0] REG_INSTR_LIMIT  = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [WORD_W-1:0] instr_addr;
        logic [WORD_W-1:0] stack_ptr;
        logic [WORD_W-1:0] reg_a;
        logic [WORD_W-1:0] reg_b;
        logic [WORD_W-1:0] reg_c;
        logic [WORD_W-1:0] reg_d;
        logic [WORD_W-1:0] space_id;
        logic [WORD_W-1:0] stamp;
        logic [POS_W-1:0]  read_pos;
    } cmd_t;

    typedef struct packed {
        logic              handled;
        logic              armed;
        logic [HELD_W-1:0] held_count;
        logic              read_valid;
        logic [WORD_W-1:0] out_addr;
        logic [WORD_W-1:0] out_stack;
        logic [WORD_W-1:0] out_a;
        logic [WORD_W-1:0] out_b;
        logic [WORD_W-1:0] out_c;
        logic [WORD_W-1:0] out_d;
        logic [WORD_W-1:0] out_space;
        logic [WORD_W-1:0] out_stamp;
    } res_t;

    typedef struct packed {
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] stack;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        logic [WORD_W-1:0] space;
        logic [WORD_W-1:0] stamp;
    } entry_t;

endpackage

/* design/ftr_ring_ram.sv */
module ftr_ring_ram
    import ftr_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [PTR_W-1:0] waddr,
    input  entry_t           wdata,
    input  logic             re,
    input  logic [PTR_W-1:0] raddr,
    output entry_t           rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/filtered_instruction_trace_ring_unit.sv */
// Filtered instruction trace ring.
// Command channel (cmd_valid/cmd_stall/cmd): step events, arm, disarm, clear
// and entry reads. Result channel (res_valid/res_stall/res): one transfer per
// command, in command order.
// Step, arm, disarm and clear results appear in the cycle after the command
// transfer; a step updates head, count and the entry RAM in that same cycle.
// A read passes through the registered read port of the entry RAM and then the
// result register; the command side stalls in ST_READ while the read completes.
// One command is taken per cycle while res_stall is low; a read holds the next one.
// A single result register sits between the channels; a new command is taken
// while that result is being transferred, and cmd_stall also rises while it
// is held by res_stall.
// The APB port sets space_filter (0x00), end_address (0x08) and instr_limit
// (0x10); write it only while the block is idle.
// Reset clears head, count, step counter, armed flag and the registers; RAM
// contents are left as they are and are only returned after being written.
module filtered_instruction_trace_ring_unit
    import ftr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  cmd_t              cmd,

    output logic              res_valid,
    input  logic              res_stall,
    output res_t              res,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0] pwdata,
    output logic [WORD_W-1:0] prdata,
    output logic              pready
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic              armed_reg, armed_next;
    logic [WORD_W-1:0] tally_reg, tally_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg, res_next;

    logic [WORD_W-1:0] space_filter_reg;
    logic [WORD_W-1:0] end_address_reg;
    logic [WORD_W-1:0] instr_limit_reg;

    logic              accept;
    logic              space_ok;
    logic              stop;
    logic              ram_we;
    logic              ram_re;
    entry_t            ram_wdata;
    entry_t            ram_rdata;
    logic              pos_ok;
    logic [CNT_W:0]    idx_sum;
    logic [PTR_W-1:0]  rd_idx;
    logic              cfg_we;
    logic [RIDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:3];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            space_filter_reg <= '0;
            end_address_reg  <= '0;
            instr_limit_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_SPACE_FILTER: space_filter_reg <= pwdata;
                REG_END_ADDRESS:  end_address_reg  <= pwdata;
                REG_INSTR_LIMIT:  instr_limit_reg  <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_SPACE_FILTER: prdata = space_filter_reg;
            REG_END_ADDRESS:  prdata = end_address_reg;
            REG_INSTR_LIMIT:  prdata = instr_limit_reg;
            default:          prdata = '0;
        endcase
    end

    assign cmd_stall = (state_reg != ST_IDLE) || (res_valid_reg && res_stall);
    assign accept    = cmd_valid && !cmd_stall;

    assign space_ok = (space_filter_reg == '0) || (cmd.space_id == space_filter_reg);
    assign stop     = ((instr_limit_reg != '0) && (tally_reg >= instr_limit_reg))
                   || ((end_address_reg != '0) && (cmd.instr_addr == end_address_reg));

    // oldest entry sits at head - total (mod depth); pos < total keeps sum below 2*DEPTH
    assign pos_ok  = CNT_W'(cmd.read_pos) < total_reg;
    assign idx_sum = (CNT_W+1)'(head_reg) + (CNT_W+1)'(DEPTH) - (CNT_W+1)'(total_reg)
                   + (CNT_W+1)'(cmd.read_pos);
    assign rd_idx  = (idx_sum >= (CNT_W+1)'(DEPTH)) ? PTR_W'(idx_sum - (CNT_W+1)'(DEPTH))
                                                      : PTR_W'(idx_sum);

    assign ram_wdata.addr  = cmd.instr_addr;
    assign ram_wdata.stack = cmd.stack_ptr;
    assign ram_wdata.a     = cmd.reg_a;
    assign ram_wdata.b     = cmd.reg_b;
    assign ram_wdata.c     = cmd.reg_c;
    assign ram_wdata.d     = cmd.reg_d;
    assign ram_wdata.space = cmd.space_id;
    assign ram_wdata.stamp = cmd.stamp;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        total_next     = total_reg;
        armed_next     = armed_reg;
        tally_next     = tally_reg;
        rd_valid_next  = rd_valid_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next.handled = 1'b0;
                    case (cmd.func)
                        FN_STEP:
                        begin
                            if (armed_reg && space_ok)
                            begin
                                res_next.handled = 1'b1;
                                if (stop)
                                begin
                                    armed_next = 1'b0;
                                end
                                else
                                begin
                                    ram_we     = 1'b1;
                                    head_next  = (head_reg == PTR_W'(DEPTH - 1)) ? '0
                                               : head_reg + 1'b1;
                                    total_next = (total_reg < CNT_W'(DEPTH)) ? total_reg + 1'b1
                                               : total_reg;
                                    tally_next = tally_reg + 1'b1;
                                end
                            end
                        end
                        FN_ARM:
                        begin
                            head_next  = '0;
                            total_next = '0;
                            tally_next = '0;
                            armed_next = 1'b1;
                        end
                        FN_DISARM:
                        begin
                            armed_next = 1'b0;
                        end
                        FN_CLEAR:
                        begin
                            head_next  = '0;
                            total_next = '0;
                        end
                        FN_READ:
                        begin
                            ram_re        = 1'b1;
                            rd_valid_next = pos_ok;
                            state_next    = ST_READ;
                        end
                        default: ;
                    endcase

                    if (cmd.func != FN_READ)
                    begin
                        res_next.armed      = armed_next;
                        res_next.held_count = HELD_W'(total_next);
                        res_next.read_valid = 1'b0;
                        res_next.out_addr   = '0;
                        res_next.out_stack  = '0;
                        res_next.out_a      = '0;
                        res_next.out_b      = '0;
                        res_next.out_c      = '0;
                        res_next.out_d      = '0;
                        res_next.out_space  = '0;
                        res_next.out_stamp  = '0;
                        res_valid_next      = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                res_next.handled    = 1'b0;
                res_next.armed      = armed_reg;
                res_next.held_count = HELD_W'(total_reg);
                res_next.read_valid = rd_valid_reg;
                res_next.out_addr   = rd_valid_reg ? ram_rdata.addr  : '0;
                res_next.out_stack  = rd_valid_reg ? ram_rdata.stack : '0;
                res_next.out_a      = rd_valid_reg ? ram_rdata.a     : '0;
                res_next.out_b      = rd_valid_reg ? ram_rdata.b     : '0;
                res_next.out_c      = rd_valid_reg ? ram_rdata.c     : '0;
                res_next.out_d      = rd_valid_reg ? ram_rdata.d     : '0;
                res_next.out_space  = rd_valid_reg ? ram_rdata.space : '0;
                res_next.out_stamp  = rd_valid_reg ? ram_rdata.stamp : '0;
                res_valid_next      = 1'b1;
                state_next          = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    ftr_ring_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            total_reg     <= '0;
            armed_reg     <= 1'b0;
            tally_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            total_reg     <= total_next;
            armed_reg     <= armed_next;
            tally_reg     <= tally_next;
            rd_valid_reg  <= rd_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(DEPTH))
        else $error("entry count above ring depth");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd.func == FN_READ) |=> (state_reg == ST_READ) ##1 res_valid_reg)
        else $error("read transfer did not produce a result two cycles later");

    a_invalid_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.read_valid |-> (res_reg.out_addr == '0)
            && (res_reg.out_stamp == '0))
        else $error("invalid read carries entry data");

    a_no_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_IDLE) && !ram_re)
        else $error("ring write overlaps a pending read");

endmodule

/* test/filtered_instruction_trace_ring_unit_tb.sv */
`timescale 1ns / 1ps

module filtered_instruction_trace_ring_unit_tb;
    import ftr_pkg::*;

    localparam logic [FUNC_W-1:0] FN_SPARE_MIN = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_MAX = 3'd7;
    localparam int N_FIELDS = 12;
    localparam int MAX_REPORTS = 10;

    logic              clk;
    logic              rst_n;
    logic              cmd_valid;
    logic              cmd_stall;
    cmd_t              cmd;
    logic              res_valid;
    logic              res_stall;
    res_t              res;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [WORD_W-1:0] pwdata;
    logic [WORD_W-1:0] prdata;
    logic              pready;

    filtered_instruction_trace_ring_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // trace ring shadow
    entry_t      ring_log [DEPTH];
    int unsigned log_head;
    int unsigned log_count;
    bit          log_armed;
    logic [63:0] step_count;
    logic [63:0] cfg_space;
    logic [63:0] cfg_stop_addr;
    logic [63:0] cfg_limit;

    res_t trace_expect_q [$];

    typedef struct {
        bit          is_cfg;
        logic [63:0] filt;
        logic [63:0] stop_addr;
        logic [63:0] limit;
        cmd_t        c;
        bit          typed;
        res_t        want;
    } dir_row_t;

    typedef struct {
        bit          tx;
        bit          rx;
        bit          fill;
        logic [63:0] filt;
        logic [63:0] stop_addr;
        logic [63:0] limit;
        int          n;
    } phase_t;

    dir_row_t dir_rows [$];
    phase_t   phases [5];

    bit tx_idle;
    bit rx_idle;
    int idle_pct;
    int rx_hold;

    int errors;
    int n_cmds;
    int n_directed;
    int n_checked;
    int n_valid_reads;
    int n_stops;
    int max_held;

    string field_names [N_FIELDS] = '{"handled", "armed", "held_count", "read_valid",
        "out_addr", "out_stack", "out_a", "out_b", "out_c", "out_d", "out_space",
        "out_stamp"};

    always #10 clk = ~clk;

    function automatic res_t predict_trace(input cmd_t c);
        res_t        r;
        int unsigned idx;
        r = '0;
        case (c.func)
            FN_STEP:
                if (log_armed && (cfg_space == 0 || c.space_id == cfg_space))
                begin
                    r.handled = 1'b1;
                    if ((cfg_limit != 0 && step_count >= cfg_limit) ||
                        (cfg_stop_addr != 0 && c.instr_addr == cfg_stop_addr))
                    begin
                        log_armed = 1'b0;
                        n_stops++;
                    end
                    else
                    begin
                        ring_log[log_head] = '{c.instr_addr, c.stack_ptr, c.reg_a, c.reg_b,
                                               c.reg_c, c.reg_d, c.space_id, c.stamp};
                        log_head = (log_head + 1) % DEPTH;
                        if (log_count < DEPTH)
                            log_count++;
                        step_count++;
                    end
                end
            FN_ARM:
            begin
                step_count = '0;
                log_head   = 0;
                log_count  = 0;
                log_armed  = 1'b1;
            end
            FN_DISARM:
                log_armed = 1'b0;
            FN_CLEAR:
            begin
                log_head  = 0;
                log_count = 0;
            end
            FN_READ:
                if (c.read_pos < log_count)
                begin
                    idx          = (log_head + DEPTH - log_count + c.read_pos) % DEPTH;
                    r.read_valid = 1'b1;
                    r.out_addr   = ring_log[idx].addr;
                    r.out_stack  = ring_log[idx].stack;
                    r.out_a      = ring_log[idx].a;
                    r.out_b      = ring_log[idx].b;
                    r.out_c      = ring_log[idx].c;
                    r.out_d      = ring_log[idx].d;
                    r.out_space  = ring_log[idx].space;
                    r.out_stamp  = ring_log[idx].stamp;
                    n_valid_reads++;
                end
            default: ;
        endcase
        r.armed      = log_armed;
        r.held_count = HELD_W'(log_count);
        if (log_count > max_held)
            max_held = log_count;
        return r;
    endfunction

    function automatic logic [63:0] res_field(input res_t r, input int k);
        case (k)
            0:       return 64'(r.handled);
            1:       return 64'(r.armed);
            2:       return 64'(r.held_count);
            3:       return 64'(r.read_valid);
            4:       return r.out_addr;
            5:       return r.out_stack;
            6:       return r.out_a;
            7:       return r.out_b;
            8:       return r.out_c;
            9:       return r.out_d;
            10:      return r.out_space;
            default: return r.out_stamp;
        endcase
    endfunction

    function automatic void report_error(input string what, input logic [63:0] want,
                                         input logic [63:0] got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endfunction

    function automatic void check_result(input res_t got);
        res_t want;
        if (trace_expect_q.size() == 0)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: result transfer with nothing expected: %h", $realtime, got);
            return;
        end
        want = trace_expect_q.pop_front();
        n_checked++;
        for (int k = 0; k < N_FIELDS; k++)
            if (res_field(got, k) !== res_field(want, k))
                report_error(field_names[k], res_field(want, k), res_field(got, k));
    endfunction

    function automatic logic [63:0] rand_word();
        int unsigned r;
        r = $urandom_range(15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic cmd_t make_cmd(input logic [FUNC_W-1:0] f, input logic [63:0] addr,
                                      input logic [63:0] space, input logic [63:0] fillv,
                                      input logic [POS_W-1:0] pos);
        cmd_t c;
        c.func       = f;
        c.instr_addr = addr;
        c.stack_ptr  = fillv;
        c.reg_a      = fillv;
        c.reg_b      = fillv;
        c.reg_c      = fillv;
        c.reg_d      = fillv;
        c.space_id   = space;
        c.stamp      = fillv;
        c.read_pos   = pos;
        return c;
    endfunction

    function automatic cmd_t rand_cmd(input bit fill_only);
        cmd_t        c;
        int unsigned r;
        c = make_cmd(FN_STEP, rand_word(), rand_word(), '0, POS_W'($urandom_range(DEPTH - 1)));
        c.stack_ptr = rand_word();
        c.reg_a     = rand_word();
        c.reg_b     = rand_word();
        c.reg_c     = rand_word();
        c.reg_d     = rand_word();
        c.stamp     = rand_word();
        r = $urandom_range(99);
        if (fill_only)
            c.func = (r < 92) ? FN_STEP : FN_READ;
        else if (r < 60)
            c.func = FN_STEP;
        else if (r < 80)
            c.func = FN_READ;
        else if (r < 86)
            c.func = FN_ARM;
        else if (r < 90)
            c.func = FN_DISARM;
        else if (r < 94)
            c.func = FN_CLEAR;
        else
            c.func = FUNC_W'($urandom_range(FN_SPARE_MAX, FN_SPARE_MIN));
        if (cfg_space != 0 && $urandom_range(9) < 8)
            c.space_id = cfg_space;
        if (cfg_stop_addr != 0 && $urandom_range(24) == 0)
            c.instr_addr = cfg_stop_addr;
        if (c.func == FN_READ && log_count != 0 && $urandom_range(1) == 1)
            c.read_pos = POS_W'($urandom_range(log_count - 1));
        return c;
    endfunction

    function automatic res_t status(input bit h, input bit a, input int held);
        res_t r;
        r            = '0;
        r.handled    = h;
        r.armed      = a;
        r.held_count = HELD_W'(held);
        return r;
    endfunction

    function automatic void add_cmd(input cmd_t c, input bit typed, input res_t want);
        dir_row_t row;
        row.is_cfg    = 1'b0;
        row.filt      = '0;
        row.stop_addr = '0;
        row.limit     = '0;
        row.c         = c;
        row.typed     = typed;
        row.want      = want;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [63:0] f, input logic [63:0] e,
                                    input logic [63:0] l);
        dir_row_t row;
        row.is_cfg    = 1'b1;
        row.filt      = f;
        row.stop_addr = e;
        row.limit     = l;
        row.c         = '0;
        row.typed     = 1'b0;
        row.want      = '0;
        dir_rows.push_back(row);
    endfunction

    task automatic send_cmd(input cmd_t c, input bit typed, input res_t want);
        res_t predicted;
        while (tx_idle && $urandom_range(99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        predicted = predict_trace(c);
        trace_expect_q.push_back(typed ? want : predicted);
        n_cmds++;
    endtask

    task automatic drain_results();
        cmd_valid <= 1'b0;
        while (trace_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(input logic [RIDX_W-1:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== val)
            report_error("register readback", val, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [63:0] f, input logic [63:0] e,
                              input logic [63:0] l);
        drain_results();
        reg_write(REG_SPACE_FILTER, f);
        reg_write(REG_END_ADDRESS, e);
        reg_write(REG_INSTR_LIMIT, l);
        @(posedge clk);
        cfg_space     = f;
        cfg_stop_addr = e;
        cfg_limit     = l;
    endtask

    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
                check_result(res);
            if (rx_hold > 0)
            begin
                res_stall <= 1'b1;
                rx_hold--;
            end
            else
                res_stall <= rx_idle && ($urandom_range(99) < idle_pct);
        end
    end

    initial
    begin
        #10_000_000;
        $display("filtered_instruction_trace_ring_unit regression: fail");
        $finish;
    end

    initial
    begin
        cmd_t c;

        clk       = 1'b0;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        tx_idle   = 1'b0;
        rx_idle   = 1'b0;
        idle_pct  = 71;
        rx_hold   = 0;
        errors    = 0;
        n_cmds    = 0;
        n_checked = 0;
        n_valid_reads = 0;
        n_stops   = 0;
        max_held  = 0;
        log_head  = 0;
        log_count = 0;
        log_armed = 1'b0;
        step_count    = '0;
        cfg_space     = '0;
        cfg_stop_addr = '0;
        cfg_limit     = '0;

        add_cmd(make_cmd(FN_READ, '0, '0, '0, '0), 1, status(0, 0, 0));
        add_cmd(make_cmd(FN_STEP, 64'h40, '0, '0, '0), 1, status(0, 0, 0));
        add_cmd(make_cmd(FN_SPARE_MAX, '0, '0, '0, '0), 1, status(0, 0, 0));
        add_cmd(make_cmd(FN_DISARM, '0, '0, '0, '0), 1, status(0, 0, 0));
        add_cmd(make_cmd(FN_ARM, '0, '0, '0, '0), 1, status(0, 1, 0));
        add_cmd(make_cmd(FN_STEP, '1, '1, '1, '1), 1, status(1, 1, 1));
        add_cmd(make_cmd(FN_STEP, '0, '0, '0, '0), 1, status(1, 1, 2));
        add_cmd(make_cmd(FN_READ, '0, '0, '0, '0), 0, '0);
        add_cmd(make_cmd(FN_READ, '0, '0, '0, 10'd1), 0, '0);
        add_cmd(make_cmd(FN_READ, '0, '0, '0, '1), 1, status(0, 1, 2));
        add_cmd(make_cmd(FN_SPARE_MIN, '1, '1, '1, '1), 1, status(0, 1, 2));
        add_cmd(make_cmd(FN_CLEAR, '0, '0, '0, '0), 1, status(0, 1, 0));
        add_cmd(make_cmd(FN_READ, '0, '0, '0, '0), 1, status(0, 1, 0));
        add_cmd(make_cmd(FN_STEP, {$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, '0), 0, '0);
        add_cmd(make_cmd(FN_DISARM, '0, '0, '0, '0), 1, status(0, 0, 1));
        add_cmd(make_cmd(FN_STEP, 64'h80, '0, '1, '0), 1, status(0, 0, 1));
        add_cmd(make_cmd(FN_READ, '0, '0, '0, '0), 0, '0);
        add_cmd(make_cmd(FN_ARM, '0, '0, '0, '0), 1, status(0, 1, 0));
        // filter and stop address at all ones, limit of two steps
        add_cfg('1, '1, 64'd2);
        add_cmd(make_cmd(FN_STEP, 64'h100, '0, '1, '0), 1, status(0, 1, 0));
        add_cmd(make_cmd(FN_STEP, 64'h104, '1, '1, '0), 1, status(1, 1, 1));
        add_cmd(make_cmd(FN_STEP, '1, '1, '1, '0), 1, status(1, 0, 1));
        add_cmd(make_cmd(FN_ARM, '0, '0, '0, '0), 1, status(0, 1, 0));
        add_cmd(make_cmd(FN_STEP, 64'h200, '1, 64'h5a5a, '0), 1, status(1, 1, 1));
        add_cmd(make_cmd(FN_STEP, 64'h204, '1, 64'ha5a5, '0), 1, status(1, 1, 2));
        add_cmd(make_cmd(FN_STEP, 64'h208, '1, '0, '0), 1, status(1, 0, 2));

        phases[0] = '{0, 0, 1, 64'd0, 64'd0, 64'd0, 1150};
        phases[1] = '{1, 0, 0, {32'd0, $urandom | 32'd1}, {$urandom, $urandom}, 64'd0, 150};
        phases[2] = '{0, 1, 0, 64'd0, 64'd0, 64'd25, 150};
        phases[3] = '{1, 1, 0, '1, '1, '1, 150};
        phases[4] = '{0, 0, 0, {$urandom, $urandom}, {$urandom | 32'd1, $urandom},
                      64'd1, 150};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                set_config(dir_rows[i].filt, dir_rows[i].stop_addr, dir_rows[i].limit);
            else
                send_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);
        end
        n_directed = n_cmds;

        foreach (phases[p])
        begin
            set_config(phases[p].filt, phases[p].stop_addr, phases[p].limit);
            tx_idle  = phases[p].tx;
            rx_idle  = phases[p].rx;
            idle_pct = (phases[p].tx && phases[p].rx) ? 31 : 71;
            send_cmd(make_cmd(FN_ARM, '0, '0, '0, '0), 0, '0);
            for (int i = 0; i < phases[p].n; i++)
            begin
                // long receiver hold while commands keep coming
                if (p == 0 && i == 300)
                    rx_hold = 400;
                if (p == 2 && i == 75)
                    drain_results();
                c = rand_cmd(phases[p].fill);
                send_cmd(c, 0, '0);
            end
        end

        tx_idle = 1'b0;
        rx_idle = 1'b0;
        drain_results();
        repeat (20) @(posedge clk);

        $display("Covered %0d commands (%0d directed) across 6 register settings and",
                 n_cmds, n_directed);
        $display("4 stall patterns: %0d results, %0d valid reads, %0d stop hits, peak fill %0d",
                 n_checked, n_valid_reads, n_stops, max_held);
        if (errors == 0 && trace_expect_q.size() == 0)
            $display("filtered_instruction_trace_ring_unit regression: pass");
        else
            $display("filtered_instruction_trace_ring_unit regression: fail");
        $finish;
    end

endmodule
